FILE: rtl/fpa_pkg.sv
package fpa_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_GT   = 4'd4,
        OP_LT   = 4'd5,
        OP_GE   = 4'd6,
        OP_LE   = 4'd7,
        OP_EQ   = 4'd8,
        OP_NE   = 4'd9,
        OP_MIN  = 4'd10,
        OP_MAX  = 4'd11,
        OP_INC  = 4'd12,
        OP_DEC  = 4'd13,
        OP_TOI  = 4'd14,
        OP_FRI  = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

endpackage

FILE: rtl/fpa_div.sv
module fpa_div #(
    parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [WORD_BITS-1:0] num_mag,
    input  logic [WORD_BITS-1:0] den_mag,
    output logic [WORD_BITS+FRAC_BITS-1:0] quot,
    output logic                 round_up
);
    import fpa_pkg::*;

    localparam int NB = WORD_BITS + FRAC_BITS;
    localparam int RB = WORD_BITS + 1;

    // one quotient bit per stage, restoring
    logic [RB-1:0]        rem_reg  [0:NB];
    logic [NB-1:0]        num_reg  [0:NB];
    logic [NB-1:0]        q_reg    [0:NB];
    logic [WORD_BITS-1:0] den_reg  [0:NB];

    always_comb begin
        rem_reg[0] = '0;
        num_reg[0] = {num_mag, {FRAC_BITS{1'b0}}};
        q_reg[0]   = '0;
        den_reg[0] = den_mag;
    end

    for (genvar i = 0; i < NB; i++) begin : g_stage
        logic [RB-1:0] sh;
        logic [RB-1:0] df;
        logic          ge;
        always_comb begin
            sh = {rem_reg[i][RB-2:0], num_reg[i][NB-1]};
            df = sh - {1'b0, den_reg[i]};
            ge = sh >= {1'b0, den_reg[i]};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i+1] <= ge ? df : sh;
                num_reg[i+1] <= {num_reg[i][NB-2:0], 1'b0};
                q_reg[i+1]   <= {q_reg[i][NB-2:0], ge};
                den_reg[i+1] <= den_reg[i];
            end
        end
    end

    assign quot     = q_reg[NB];
    assign round_up = {rem_reg[NB], 1'b0} >= {1'b0, den_reg[NB]};
endmodule

FILE: rtl/fixed_point_alu.sv
// Signed fixed-point ALU, WORD_BITS raw values with FRAC_BITS fraction bits
// (Q24.8 by default). One item may enter every clock while the output is not
// stalled. Non-divide results pass a delay line that matches the divider
// pipeline, which resolves one quotient bit per stage, so order is kept across
// all operations. Rounding is half away from zero, and results out of range
// saturate with status 1; divide by zero gives status 2.
// tready on the slave side is m_tready or an empty output: the whole pipe stalls together.
module fixed_point_alu #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // operation, operand_a, operand_b (tdata rounded up to bytes)
    input  logic [((4+2*WORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // result_value, compare_true, status
    output logic [((WORD_BITS+3+7)/8)*8-1:0] m_tdata
);
    import fpa_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int NB  = W + F;
    localparam int LAT = NB + 1;
    localparam int SW  = ((4+2*W+7)/8)*8;
    localparam int MW  = ((W+3+7)/8)*8;
    localparam int PW  = 2*W + 1;

    logic en;
    assign en       = m_tready || !m_tvalid;
    assign s_tready = en;

    logic [3:0]   op_in;
    logic [W-1:0] a_in, b_in;
    assign op_in = s_tdata[3:0];
    assign a_in  = s_tdata[4 +: W];
    assign b_in  = s_tdata[4+W +: W];

    // stage 1: signs, magnitudes, compares
    logic         v1_reg;
    logic [3:0]   op1_reg;
    logic [W-1:0] a1_reg, b1_reg, ma1_reg, mb1_reg;
    logic         na1_reg, nb1_reg, gt1_reg, eq1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
        if (en) begin
            op1_reg <= op_in;
            a1_reg  <= a_in;
            b1_reg  <= b_in;
            na1_reg <= a_in[W-1];
            nb1_reg <= b_in[W-1];
            ma1_reg <= a_in[W-1] ? (W)'(-a_in) : a_in;
            mb1_reg <= b_in[W-1] ? (W)'(-b_in) : b_in;
            gt1_reg <= $signed(a_in) > $signed(b_in);
            eq1_reg <= a_in == b_in;
        end
    end

    // stage 2: product, sum, misc results; pre-pack magnitude
    logic [PW-1:0] mag2_next, mag2_reg;
    logic          neg2_next, neg2_reg, v2_reg;
    logic [3:0]    op2_reg;
    logic [W-1:0]  raw2_next, raw2_reg;
    logic          cmp2_next, cmp2_reg, raw2s_next, raw2s_reg;
    logic          dz2_reg;

    logic [2*W-1:0] prod;
    logic [W:0]     sa, sb;
    logic [W+1:0]   ssum;
    logic           bsub;

    always_comb begin
        prod = ma1_reg * mb1_reg;
        bsub = (op1_reg == OP_SUB) || (op1_reg == OP_DEC);
        sa   = {a1_reg[W-1], a1_reg};
        sb   = (op1_reg == OP_INC || op1_reg == OP_DEC) ? (W+1)'(1) : {b1_reg[W-1], b1_reg};
        ssum = bsub ? {sa[W], sa} - {sb[W], sb} : {sa[W], sa} + {sb[W], sb};
        mag2_next  = '0;
        neg2_next  = 1'b0;
        raw2_next  = '0;
        raw2s_next = 1'b0;
        cmp2_next  = 1'b0;
        case (op1_reg)
            OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
                neg2_next = ssum[W+1];
                mag2_next = PW'(ssum[W+1] ? (W+2)'(-ssum) : ssum);
            end
            OP_MUL: begin
                neg2_next = na1_reg ^ nb1_reg;
                mag2_next = PW'((PW'(prod) + PW'(1 << (F-1))) >> F);
            end
            OP_TOI: begin
                neg2_next = na1_reg;
                mag2_next = PW'((PW'(ma1_reg) + PW'(1 << (F-1))) >> F);
            end
            OP_FRI: begin
                neg2_next = nb1_reg;
                mag2_next = PW'(mb1_reg) << F;
            end
            OP_GT: cmp2_next = gt1_reg;
            OP_LT: cmp2_next = !gt1_reg && !eq1_reg;
            OP_GE: cmp2_next = gt1_reg || eq1_reg;
            OP_LE: cmp2_next = !gt1_reg;
            OP_EQ: cmp2_next = eq1_reg;
            OP_NE: cmp2_next = !eq1_reg;
            OP_MIN: begin
                raw2s_next = 1'b1;
                raw2_next  = gt1_reg ? b1_reg : a1_reg;
            end
            OP_MAX: begin
                raw2s_next = 1'b1;
                raw2_next  = (gt1_reg || eq1_reg) ? a1_reg : b1_reg;
            end
            default: begin
                neg2_next = na1_reg ^ nb1_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            op2_reg   <= op1_reg;
            mag2_reg  <= mag2_next;
            neg2_reg  <= neg2_next;
            raw2_reg  <= raw2_next;
            raw2s_reg <= raw2s_next;
            cmp2_reg  <= cmp2_next;
            dz2_reg   <= mb1_reg == '0;
        end
    end

    // divider runs from stage 1 in parallel
    logic [NB-1:0] quot;
    logic          qround;
    fpa_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div (
        .aclk     (aclk),
        .en       (en),
        .num_mag  (ma1_reg),
        .den_mag  (mb1_reg),
        .quot     (quot),
        .round_up (qround)
    );

    // delay line for the non-divide path, aligned to divider output
    localparam int DL = NB - 1;
    logic [PW-1:0] dmag_reg  [0:DL];
    logic          dneg_reg  [0:DL];
    logic [3:0]    dop_reg   [0:DL];
    logic [W-1:0]  draw_reg  [0:DL];
    logic          draws_reg [0:DL];
    logic          dcmp_reg  [0:DL];
    logic          ddz_reg   [0:DL];
    logic          dv_reg    [0:DL];

    always_comb begin
        dmag_reg[0]  = mag2_reg;
        dneg_reg[0]  = neg2_reg;
        dop_reg[0]   = op2_reg;
        draw_reg[0]  = raw2_reg;
        draws_reg[0] = raw2s_reg;
        dcmp_reg[0]  = cmp2_reg;
        ddz_reg[0]   = dz2_reg;
        dv_reg[0]    = v2_reg;
    end

    for (genvar k = 0; k < DL; k++) begin : g_dly
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_reg[k+1] <= dv_reg[k];
            end
            if (en) begin
                dmag_reg[k+1]  <= dmag_reg[k];
                dneg_reg[k+1]  <= dneg_reg[k];
                dop_reg[k+1]   <= dop_reg[k];
                draw_reg[k+1]  <= draw_reg[k];
                draws_reg[k+1] <= draws_reg[k];
                dcmp_reg[k+1]  <= dcmp_reg[k];
                ddz_reg[k+1]   <= ddz_reg[k];
            end
        end
    end

    // stage 3: round quotient, saturate, pack into output register
    logic [PW-1:0] fmag;
    logic [PW-1:0] lim;
    logic [W-1:0]  res_next;
    logic [1:0]    st_next;
    logic          cmp_next;
    logic          isdiv;

    always_comb begin
        isdiv    = dop_reg[DL] == OP_DIV;
        fmag     = isdiv ? PW'(quot) + PW'(qround) : dmag_reg[DL];
        lim      = dneg_reg[DL] ? PW'(1) << (W-1) : (PW'(1) << (W-1)) - PW'(1);
        cmp_next = dcmp_reg[DL];
        st_next  = ST_OK;
        res_next = '0;
        if (draws_reg[DL]) begin
            res_next = draw_reg[DL];
        end else if (isdiv && ddz_reg[DL]) begin
            st_next = ST_DIVZ;
        end else if (fmag > lim) begin
            st_next  = ST_SAT;
            res_next = dneg_reg[DL] ? (W)'(-lim[W-1:0]) : lim[W-1:0];
        end else begin
            res_next = dneg_reg[DL] ? (W)'(-fmag[W-1:0]) : fmag[W-1:0];
        end
    end

    logic         vo_reg;
    logic [W-1:0] res_reg;
    logic [1:0]   st_reg;
    logic         cmp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= dv_reg[DL];
        end
        if (en) begin
            res_reg <= res_next;
            st_reg  <= st_next;
            cmp_reg <= cmp_next;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = MW'({st_reg, cmp_reg, res_reg});

    logic unused_ok;
    assign unused_ok = ^{s_tdata[SW-1:4+2*W], LAT[0]} | 1'b0;
endmodule

FILE: rtl/fpa_checker.sv
module fpa_checker #(
    parameter int MW = 40
) (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_tready,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [MW-1:0] m_tdata
);
    // stalled item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed under stall");

    // status never takes the unused code
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[34:33] != 2'd3)
        else $error("bad status");

    // input side open whenever output is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // a true compare comes with ok status
    a_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> m_tdata[34:33] == 2'd0)
        else $error("compare with status");
endmodule

bind fixed_point_alu fpa_checker #(.MW(((WORD_BITS+3+7)/8)*8)) u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/tb_fixed_point_alu.sv
`timescale 1ns / 100ps

module tb_fixed_point_alu;
    import fpa_pkg::*;

    localparam int FB = 8;
    localparam int WB = 32;
    localparam int SW = ((4 + 2 * WB + 7) / 8) * 8;
    localparam int MW = ((WB + 3 + 7) / 8) * 8;
    localparam int LAT = WB + FB + 1;
    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 1600;

    typedef struct packed {
        logic [WB-1:0] value;
        logic          cmp;
        logic [1:0]    status;
    } alu_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [SW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [MW-1:0] m_tdata;

    logic [SW-1:0] pending_items[$];
    alu_result_t expected_results[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit stim_done = 1'b0;
    bit quiet = 1'b0;
    bit hold_long = 1'b0;
    int hold_count = 0;
    int src_gap = 0;
    int sink_gap = 0;

    fixed_point_alu #(.FRAC_BITS(FB), .WORD_BITS(WB)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [WB-1:0] saturate(bit neg, logic [127:0] mag,
                                               inout logic [1:0] st);
        logic [127:0] lim;
        logic [127:0] m;
        lim = neg ? (128'd1 << (WB - 1)) : ((128'd1 << (WB - 1)) - 1);
        m = mag;
        if (mag > lim) begin
            m = lim;
            st = ST_SAT;
        end
        return neg ? WB'(-m) : WB'(m);
    endfunction

    function automatic alu_result_t alu_predict(logic [SW-1:0] item);
        op_t op;
        logic signed [WB-1:0] a, b;
        logic [127:0] ma, mb, w, q, r;
        bit na, nb;
        logic signed [129:0] sum;
        alu_result_t res;
        op = op_t'(item[3:0]);
        a = item[4 +: WB];
        b = item[4 + WB +: WB];
        na = a[WB-1];
        nb = b[WB-1];
        ma = 128'(unsigned'(a));
        mb = 128'(unsigned'(b));
        if (na) ma = (128'd1 << WB) - 128'(unsigned'(a));
        if (nb) mb = (128'd1 << WB) - 128'(unsigned'(b));
        res = '0;
        res.status = ST_OK;
        case (op)
            OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
                if (op == OP_ADD) sum = 130'(a) + 130'(b);
                else if (op == OP_SUB) sum = 130'(a) - 130'(b);
                else if (op == OP_INC) sum = 130'(a) + 130'sd1;
                else sum = 130'(a) - 130'sd1;
                res.value = saturate(sum < 0, sum < 0 ? 128'(-sum) : 128'(sum),
                                     res.status);
            end
            OP_MUL: begin
                w = (ma * mb + (128'd1 << (FB - 1))) >> FB;
                res.value = saturate(na != nb, w, res.status);
            end
            OP_DIV: begin
                if (mb == 0) begin
                    res.status = ST_DIVZ;
                end else begin
                    q = (ma << FB) / mb;
                    r = (ma << FB) % mb;
                    if (r >= mb - r) q = q + 1;
                    res.value = saturate(na != nb, q, res.status);
                end
            end
            OP_GT: res.cmp = a > b;
            OP_LT: res.cmp = a < b;
            OP_GE: res.cmp = a >= b;
            OP_LE: res.cmp = a <= b;
            OP_EQ: res.cmp = a == b;
            OP_NE: res.cmp = a != b;
            OP_MIN: res.value = (a > b) ? b : a;
            OP_MAX: res.value = (a >= b) ? a : b;
            OP_TOI: begin
                w = (ma + (128'd1 << (FB - 1))) >> FB;
                res.value = saturate(na, w, res.status);
            end
            default: res.value = saturate(nb, mb << FB, res.status);
        endcase
        return res;
    endfunction

    function automatic logic [SW-1:0] pack_item(op_t op, logic [WB-1:0] a,
                                                logic [WB-1:0] b);
        logic [SW-1:0] t;
        t = '0;
        t[3:0] = op;
        t[4 +: WB] = a;
        t[4 + WB +: WB] = b;
        return t;
    endfunction

    function automatic logic [WB-1:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return {1'b0, {(WB - 1){1'b1}}} - WB'($urandom_range(0, 3));
            1: return {1'b1, {(WB - 1){1'b0}}} + WB'($urandom_range(0, 3));
            2: return WB'($signed($urandom_range(0, 4096)) - 2048);
            3: return WB'($urandom_range(0, 512)) << $urandom_range(0, 20);
            default: return WB'($urandom);
        endcase
    endfunction

    initial begin
        logic [WB-1:0] max_v, min_v, a, b;
        op_t op;
        max_v = {1'b0, {(WB - 1){1'b1}}};
        min_v = {1'b1, {(WB - 1){1'b0}}};
        for (int k = 0; k < 16; k++)
            pending_items.push_back(pack_item(op_t'(k), 32'h0000_0380, 32'hffff_fe80));
        pending_items.push_back(pack_item(OP_ADD, max_v, max_v));
        pending_items.push_back(pack_item(OP_SUB, min_v, 32'd1));
        pending_items.push_back(pack_item(OP_MUL, min_v, min_v));
        pending_items.push_back(pack_item(OP_DIV, max_v, 32'd0));
        pending_items.push_back(pack_item(OP_DIV, min_v, 32'd1));
        pending_items.push_back(pack_item(OP_INC, max_v, 32'd0));
        pending_items.push_back(pack_item(OP_DEC, min_v, 32'd0));
        pending_items.push_back(pack_item(OP_FRI, 32'd0, min_v));
        pending_items.push_back(pack_item(OP_TOI, 32'hffff_ff80, 32'd0));
        for (int k = 0; k < N_RANDOM; k++) begin
            op = op_t'($urandom_range(0, 15));
            a = rand_operand();
            b = ($urandom_range(0, 7) == 0) ? a : rand_operand();
            if (op == OP_DIV && $urandom_range(0, 15) == 0) b = '0;
            pending_items.push_back(pack_item(op, a, b));
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // long receiver hold-off early in the run
    always @(posedge aclk) begin
        if (aresetn && hold_count < 200 && pending_items.size() < N_RANDOM - 50) begin
            hold_long <= 1'b1;
            hold_count <= hold_count + 1;
        end else begin
            hold_long <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            quiet <= pending_items.size() < 200;
            if (s_tvalid && s_tready) begin
                expected_results.push_back(alu_predict(s_tdata));
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_items.pop_front();
                    if (!quiet && $urandom_range(0, 9) == 0)
                        src_gap <= $urandom_range(1, 6);
                end else begin
                    s_tvalid <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        alu_result_t got, exp_r;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.value = m_tdata[WB-1:0];
                got.cmp = m_tdata[WB];
                got.status = m_tdata[WB+2:WB+1];
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: value %h cmp %b status %0d",
                                 got.value, got.cmp, got.status);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h/%b/%0d actual %h/%b/%0d",
                                     exp_r.value, exp_r.cmp, exp_r.status,
                                     got.value, got.cmp, got.status);
                    end
                end
            end
            if (hold_long) begin
                m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0)
                    sink_gap <= $urandom_range(1, 6);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (2 * LAT) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/fpa_pkg.sv
rtl/fpa_div.sv
rtl/fixed_point_alu.sv
rtl/fpa_checker.sv
tb/tb_fixed_point_alu.sv
